@@ design/flow_neighbour_angle_similarity_assert.svh @@
// assertion macros shared by the checker
`ifndef FLOW_NEIGHBOUR_ANGLE_SIMILARITY_ASSERT_SVH
`define FLOW_NEIGHBOUR_ANGLE_SIMILARITY_ASSERT_SVH

// same-cycle implication
`define FNAS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FNAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/fnas_pkg.sv @@
// ----------------------------------------------------------------------------
// fnas_pkg
// Shared types and constants of the flow neighbour angle similarity block.
// ----------------------------------------------------------------------------
package fnas_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int XY_W         = 34;
   localparam int MAG_W        = ANGLE_BITS + 4;
   localparam int SIM_W        = 19;
   localparam int CELL_W       = ANGLE_BITS + 1;
   localparam logic signed [MAG_W:0] SAT_HI = (MAG_W+1)'((2**(SIM_W-1)) - 1);
   localparam logic signed [MAG_W:0] SAT_LO = (MAG_W+1)'(-(2**(SIM_W-1)));

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GRID_STEP    = 2'd2;

   typedef struct packed {
      logic [10:0] width;
      logic [10:0] height;
      logic [4:0]  step;
   } cfg_type;

   typedef struct packed {
      logic [9:0]            row;
      logic [9:0]            col;
      logic [1:0]            slot;
      logic [ANGLE_BITS-1:0] angle;
      logic                  skip;
      logic [2:0]            emit;
   } item_type;

   typedef enum logic [1:0] {F_IDLE, F_ROT, F_PUSH, F_SYNC} front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_WRITE, B_SEL, B_READ, B_DATA, B_DIV, B_OUT
   } back_state_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

@@ design/fnas_queue.sv @@
// ----------------------------------------------------------------------------
// fnas_queue
// Four-entry register queue between the front and the back.
// ----------------------------------------------------------------------------
module fnas_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   logic [DATA_W-1:0] store_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 3'd4);
   assign pop_valid  = (count_ff != 3'd0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'd0, do_push} - {2'd0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

@@ design/fnas_front.sv @@
// ----------------------------------------------------------------------------
// fnas_front
// Raster counters, grid detection and iterative angle computation.
// ----------------------------------------------------------------------------
module fnas_front #(
   parameter int MAX_GRID_COLS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fnas_pkg::cfg_type        cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [15:0]       req_flow_x,
   input  logic signed [15:0]       req_flow_y,
   output logic                     push_valid,
   input  logic                     push_ready,
   output fnas_pkg::item_type       push_item,
   output logic [$clog2(MAX_GRID_COLS)-1:0] push_gcol
);
   import fnas_pkg::*;
   localparam int COL_W = $clog2(MAX_GRID_COLS);

   front_state_type state_ff, state_in;
   logic [9:0] row_ff, row_in, col_ff, col_in;
   logic [4:0] rph_ff, rph_in, cph_ff, cph_in;
   logic [1:0] slot_ff, slot_in;
   logic [COL_W-1:0] gcol_ff, gcol_in;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] z_ff, z_in;
   logic [4:0]  iter_ff, iter_in;
   logic        zero_ff, zero_in;
   item_type    item_ff, item_in;
   logic [COL_W-1:0] igcol_ff, igcol_in;
   logic [4:0]  step_seen_ff, step_seen_in;
   logic [9:0]  srow_ff, srow_in, scol_ff, scol_in;

   logic accept, grid;
   logic [10:0] col_nx, row_nx;
   logic [5:0]  cph_nx, rph_nx;
   logic signed [XY_W-1:0] x0, y0, sx, sy;
   logic [31:0] z_rnd;
   logic lastrow;

   assign req_ready  = (state_ff == F_IDLE) && (cfg.step == step_seen_ff);
   assign accept     = req_valid && req_ready;
   assign grid       = (rph_ff == 5'd0) && (cph_ff == 5'd0);
   assign push_valid = (state_ff == F_PUSH);
   assign z_rnd      = z_ff + (32'd1 << (31 - ANGLE_BITS));
   assign push_gcol  = igcol_ff;

   always_comb begin
      push_item = item_ff;
      push_item.angle = zero_ff ? '0 : z_rnd[31 -: ANGLE_BITS];
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_ff; col_in = col_ff;
      rph_in = rph_ff; cph_in = cph_ff;
      slot_in = slot_ff; gcol_in = gcol_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      iter_in = iter_ff; zero_in = zero_ff;
      item_in = item_ff; igcol_in = igcol_ff;
      step_seen_in = step_seen_ff;
      srow_in = srow_ff; scol_in = scol_ff;
      col_nx = {1'b0, col_ff} + 11'd1;
      row_nx = {1'b0, row_ff} + 11'd1;
      cph_nx = {1'b0, cph_ff} + 6'd1;
      rph_nx = {1'b0, rph_ff} + 6'd1;
      x0 = {{(XY_W-16){req_flow_x[15]}}, req_flow_x} <<< 14;
      y0 = {{(XY_W-16){req_flow_y[15]}}, req_flow_y} <<< 14;
      sx = y_ff >>> iter_ff;
      sy = x_ff >>> iter_ff;
      lastrow = ({1'b0, row_ff} + {6'd0, cfg.step}) >= cfg.height;

      unique case (state_ff)
         F_IDLE: begin
            if (cfg.step != step_seen_ff) begin
               // new step: rebuild the grid phase from the current position
               step_seen_in = cfg.step;
               rph_in = '0; cph_in = '0; slot_in = '0; gcol_in = '0;
               srow_in = '0; scol_in = '0;
               state_in = F_SYNC;
            end else if (accept) begin
               if (grid) begin
                  item_in.row  = row_ff;
                  item_in.col  = col_ff;
                  item_in.slot = slot_ff;
                  item_in.skip = (req_flow_x > -16'sd256) && (req_flow_x < 16'sd256) &&
                                 (req_flow_y > -16'sd256) && (req_flow_y < 16'sd256);
                  item_in.emit[0] = (row_ff != 10'd0);
                  item_in.emit[1] = lastrow && (col_ff != 10'd0);
                  item_in.emit[2] = lastrow &&
                     (({1'b0, col_ff} + {6'd0, cfg.step}) >= cfg.width);
                  igcol_in = gcol_ff;
                  zero_in  = (req_flow_x == 16'sd0) && (req_flow_y == 16'sd0);
                  iter_in  = '0;
                  if (req_flow_x[15]) begin
                     x_in = -x0; y_in = -y0; z_in = 32'h8000_0000;
                  end else begin
                     x_in = x0; y_in = y0; z_in = '0;
                  end
                  state_in = F_ROT;
               end
               // raster advance
               if (col_nx >= cfg.width) begin
                  col_in = '0; cph_in = '0; gcol_in = '0;
                  if (row_nx >= cfg.height) begin
                     row_in = '0; rph_in = '0; slot_in = '0;
                  end else begin
                     row_in = row_nx[9:0];
                     if (rph_nx >= {1'b0, cfg.step}) begin
                        rph_in  = '0;
                        slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
                     end else begin
                        rph_in = rph_nx[4:0];
                     end
                  end
               end else begin
                  col_in = col_nx[9:0];
                  if (cph_nx >= {1'b0, cfg.step}) begin
                     cph_in  = '0;
                     gcol_in = (gcol_ff == COL_W'(MAX_GRID_COLS - 1)) ? '0 : gcol_ff + 1'b1;
                  end else begin
                     cph_in = cph_nx[4:0];
                  end
               end
            end
         end
         F_ROT: begin
            if (y_ff > 0) begin
               x_in = x_ff + sx; y_in = y_ff - sy; z_in = z_ff + atan_turn(iter_ff);
            end else begin
               x_in = x_ff - sx; y_in = y_ff + sy; z_in = z_ff - atan_turn(iter_ff);
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         F_SYNC: begin
            // walk rows then columns up to the current position
            if (srow_ff != row_ff) begin
               srow_in = srow_ff + 10'd1;
               if (rph_nx >= {1'b0, cfg.step}) begin
                  rph_in  = '0;
                  slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
               end else begin
                  rph_in = rph_nx[4:0];
               end
            end else if (scol_ff != col_ff) begin
               scol_in = scol_ff + 10'd1;
               if (cph_nx >= {1'b0, cfg.step}) begin
                  cph_in  = '0;
                  gcol_in = (gcol_ff == COL_W'(MAX_GRID_COLS - 1)) ? '0 : gcol_ff + 1'b1;
               end else begin
                  cph_in = cph_nx[4:0];
               end
            end else begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         row_ff <= '0; col_ff <= '0;
         rph_ff <= '0; cph_ff <= '0;
         slot_ff <= '0; gcol_ff <= '0;
         step_seen_ff <= 5'd1;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in; col_ff <= col_in;
         rph_ff <= rph_in; cph_ff <= cph_in;
         slot_ff <= slot_in; gcol_ff <= gcol_in;
         step_seen_ff <= step_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      iter_ff <= iter_in; zero_ff <= zero_in;
      item_ff <= item_in; igcol_ff <= igcol_in;
      srow_ff <= srow_in; scol_ff <= scol_in;
   end
endmodule

@@ design/fnas_back.sv @@
// ----------------------------------------------------------------------------
// fnas_back
// Grid line buffers, neighbour difference accumulation and averaging.
// ----------------------------------------------------------------------------
module fnas_back #(
   parameter int MAX_GRID_COLS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fnas_pkg::cfg_type        cfg,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  fnas_pkg::item_type       pop_item,
   input  logic [$clog2(MAX_GRID_COLS)-1:0] pop_gcol,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [9:0]               rsp_center_row,
   output logic [9:0]               rsp_center_col,
   output logic signed [18:0]       rsp_similarity,
   output logic                     rsp_skipped,
   output logic                     rsp_last
);
   import fnas_pkg::*;
   localparam int COL_W = $clog2(MAX_GRID_COLS);
   localparam int BIT_W = $clog2(MAG_W + 1);

   logic [CELL_W-1:0] lines [3][MAX_GRID_COLS];
   logic [CELL_W-1:0] rd_ff;

   back_state_type state_ff, state_in;
   item_type it_ff, it_in;
   logic [COL_W-1:0] gcol_ff, gcol_in, pcol_ff, pcol_in;
   logic [2:0] emit_ff, emit_in, cur_ff, cur_in;
   logic [9:0] pr_ff, pr_in, pc_ff, pc_in;
   logic [1:0] ps_ff, ps_in;
   logic [2:0] step_ff, step_in, cnt_ff, cnt_in;
   logic [ANGLE_BITS-1:0] ctr_ff, ctr_in;
   logic signed [MAG_W:0] sum_ff, sum_in;
   logic [MAG_W-1:0] mag_ff, mag_in, quo_ff, quo_in;
   logic [1:0] rem_ff, rem_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic neg_ff, neg_in;
   logic [9:0] orow_ff, orow_in, ocol_ff, ocol_in;
   logic signed [18:0] osim_ff, osim_in;
   logic oskip_ff, oskip_in, olast_ff, olast_in;

   logic mem_we, mem_re, exists;
   logic [1:0] rd_slot;
   logic [COL_W-1:0] rd_col, col_dec, col_inc;
   logic [1:0] slot_dec, slot_inc;
   logic [ANGLE_BITS-1:0] diff;
   logic signed [MAG_W:0] dext, q_s;
   logic [2:0] rem_n;

   assign pop_ready      = (state_ff == B_IDLE);
   assign rsp_valid      = (state_ff == B_OUT);
   assign rsp_center_row = orow_ff;
   assign rsp_center_col = ocol_ff;
   assign rsp_similarity = osim_ff;
   assign rsp_skipped    = oskip_ff;
   assign rsp_last       = olast_ff;

   assign col_dec  = (pcol_ff == '0) ? COL_W'(MAX_GRID_COLS - 1) : pcol_ff - 1'b1;
   assign col_inc  = (pcol_ff == COL_W'(MAX_GRID_COLS - 1)) ? '0 : pcol_ff + 1'b1;
   assign slot_dec = (ps_ff == 2'd0) ? 2'd2 : ps_ff - 2'd1;
   assign slot_inc = (ps_ff == 2'd2) ? 2'd0 : ps_ff + 2'd1;

   // neighbour order: center, top, left, bottom, right
   always_comb begin
      rd_slot = ps_ff;
      rd_col  = pcol_ff;
      exists  = 1'b1;
      unique case (step_ff)
         3'd1: begin rd_slot = slot_dec; exists = (pr_ff != 10'd0); end
         3'd2: begin rd_col = col_dec; exists = (pc_ff != 10'd0); end
         3'd3: begin
            rd_slot = slot_inc;
            exists  = ({1'b0, pr_ff} + {6'd0, cfg.step}) < cfg.height;
         end
         3'd4: begin
            rd_col = col_inc;
            exists = ({1'b0, pc_ff} + {6'd0, cfg.step}) < cfg.width;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      it_in = it_ff; gcol_in = gcol_ff; pcol_in = pcol_ff;
      emit_in = emit_ff; cur_in = cur_ff;
      pr_in = pr_ff; pc_in = pc_ff; ps_in = ps_ff;
      step_in = step_ff; cnt_in = cnt_ff; ctr_in = ctr_ff; sum_in = sum_ff;
      mag_in = mag_ff; quo_in = quo_ff; rem_in = rem_ff; bit_in = bit_ff;
      neg_in = neg_ff;
      orow_in = orow_ff; ocol_in = ocol_ff; osim_in = osim_ff;
      oskip_in = oskip_ff; olast_in = olast_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      diff = ctr_ff - rd_ff[ANGLE_BITS:1];
      dext = {{(MAG_W+1-ANGLE_BITS){diff[ANGLE_BITS-1]}}, diff};
      rem_n = {rem_ff, mag_ff[MAG_W-1]};
      q_s = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               it_in = pop_item;
               gcol_in = pop_gcol;
               state_in = B_WRITE;
            end
         end
         B_WRITE: begin
            mem_we  = 1'b1;
            emit_in = it_ff.emit;
            state_in = (it_ff.emit == 3'd0) ? B_IDLE : B_SEL;
         end
         B_SEL: begin
            step_in = '0; cnt_in = '0; sum_in = '0;
            priority if (emit_ff[0]) begin
               cur_in = 3'b001;
               pr_in = it_ff.row - {5'd0, cfg.step};
               pc_in = it_ff.col;
               ps_in = (it_ff.slot == 2'd0) ? 2'd2 : it_ff.slot - 2'd1;
               pcol_in = gcol_ff;
            end else if (emit_ff[1]) begin
               cur_in = 3'b010;
               pr_in = it_ff.row;
               pc_in = it_ff.col - {5'd0, cfg.step};
               ps_in = it_ff.slot;
               pcol_in = (gcol_ff == '0) ? COL_W'(MAX_GRID_COLS - 1) : gcol_ff - 1'b1;
            end else begin
               cur_in = 3'b100;
               pr_in = it_ff.row;
               pc_in = it_ff.col;
               ps_in = it_ff.slot;
               pcol_in = gcol_ff;
            end
            state_in = B_READ;
         end
         B_READ: begin
            if (step_ff > 3'd4) begin
               orow_in = pr_ff; ocol_in = pc_ff; oskip_in = 1'b0;
               olast_in = ((emit_ff & ~cur_ff) == 3'd0);
               if (cnt_ff == 3'd0) begin
                  osim_in = '0;
                  state_in = B_OUT;
               end else begin
                  neg_in = sum_ff[MAG_W];
                  mag_in = sum_ff[MAG_W] ? MAG_W'(-sum_ff) : sum_ff[MAG_W-1:0];
                  rem_in = '0; quo_in = '0; bit_in = '0;
                  state_in = B_DIV;
               end
            end else if (exists) begin
               mem_re = 1'b1;
               state_in = B_DATA;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         B_DATA: begin
            step_in = step_ff + 3'd1;
            state_in = B_READ;
            if (step_ff == 3'd0) begin
               ctr_in = rd_ff[ANGLE_BITS:1];
               if (rd_ff[0]) begin
                  orow_in = pr_ff; ocol_in = pc_ff;
                  osim_in = '0; oskip_in = 1'b1;
                  olast_in = ((emit_ff & ~cur_ff) == 3'd0);
                  state_in = B_OUT;
               end
            end else begin
               sum_in = sum_ff + (dext <<< 2) + dext;
               cnt_in = cnt_ff + 3'd1;
            end
         end
         B_DIV: begin
            // restoring divide by the neighbour count, one bit a cycle
            if (bit_ff == BIT_W'(MAG_W)) begin
               if (q_s > SAT_HI) begin
                  osim_in = SAT_HI[18:0];
               end else if (q_s < SAT_LO) begin
                  osim_in = SAT_LO[18:0];
               end else begin
                  osim_in = q_s[18:0];
               end
               state_in = B_OUT;
            end else begin
               mag_in = mag_ff << 1;
               bit_in = bit_ff + 1'b1;
               if (rem_n >= cnt_ff) begin
                  rem_in = 2'(rem_n - cnt_ff);
                  quo_in = {quo_ff[MAG_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_n[1:0];
                  quo_in = {quo_ff[MAG_W-2:0], 1'b0};
               end
            end
         end
         B_OUT: begin
            if (rsp_ready) begin
               emit_in = emit_ff & ~cur_ff;
               state_in = ((emit_ff & ~cur_ff) == 3'd0) ? B_IDLE : B_SEL;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in; gcol_ff <= gcol_in; pcol_ff <= pcol_in;
      emit_ff <= emit_in; cur_ff <= cur_in;
      pr_ff <= pr_in; pc_ff <= pc_in; ps_ff <= ps_in;
      step_ff <= step_in; cnt_ff <= cnt_in; ctr_ff <= ctr_in; sum_ff <= sum_in;
      mag_ff <= mag_in; quo_ff <= quo_in; rem_ff <= rem_in; bit_ff <= bit_in;
      neg_ff <= neg_in;
      orow_ff <= orow_in; ocol_ff <= ocol_in; osim_ff <= osim_in;
      oskip_ff <= oskip_in; olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lines[it_ff.slot][gcol_ff] <= {it_ff.angle, it_ff.skip};
      end
      if (mem_re) begin
         rd_ff <= lines[rd_slot][rd_col];
      end
   end
endmodule

@@ design/flow_neighbour_angle_similarity.sv @@
// ----------------------------------------------------------------------------
// flow_neighbour_angle_similarity
// Neighbour angle similarity over a sampling grid of an optical-flow field.
// ----------------------------------------------------------------------------
// A pixel off the sampling grid leaves the front idle and ready for the next
// one. A grid pixel holds the input while its angle comes from a 30-step
// CORDIC that shares one rotation stage. Grid points then pass through a
// four-deep queue to the back end, which writes the line buffer and, per
// result, reads center and up to four neighbours through its single read port
// and divides by the neighbour count bit by bit; a grid pixel of the last row
// gives up to three results. After a grid step write the input stalls while
// the grid phase is rebuilt by walking the rows and columns up to the current
// raster position. Results follow one grid row behind the input; no clearing
// pass is needed.
module flow_neighbour_angle_similarity #(
   parameter int MAX_GRID_COLS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_flow_x,
   input  logic signed [15:0] req_flow_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_center_row,
   output logic [9:0]         rsp_center_col,
   output logic signed [18:0] rsp_similarity,
   output logic               rsp_skipped,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_data
);
   import fnas_pkg::*;
   localparam int COL_W = $clog2(MAX_GRID_COLS);
   localparam int Q_W   = $bits(item_type) + COL_W;

   logic [10:0] width_ff, width_in, height_ff, height_in;
   logic [4:0]  step_ff, step_in;
   cfg_type     cfg;

   logic f_valid, f_ready, b_valid, b_ready;
   item_type f_item, b_item;
   logic [COL_W-1:0] f_gcol, b_gcol;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      step_in   = step_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            CSR_GRID_STEP:    step_in   = csr_data[4:0];
            default: ;
         endcase
      end
      // out-of-range settings are used clamped
      cfg.width  = (width_ff == 11'd0) ? 11'd1 :
                   (width_ff > 11'd1024) ? 11'd1024 : width_ff;
      cfg.height = (height_ff == 11'd0) ? 11'd1 :
                   (height_ff > 11'd1024) ? 11'd1024 : height_ff;
      cfg.step   = (step_ff == 5'd0) ? 5'd1 : (step_ff > 5'd16) ? 5'd16 : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         step_ff   <= 5'd1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         step_ff   <= step_in;
      end
   end

   fnas_front #(.MAX_GRID_COLS(MAX_GRID_COLS)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_flow_x(req_flow_x), .req_flow_y(req_flow_y),
      .push_valid(f_valid), .push_ready(f_ready),
      .push_item(f_item), .push_gcol(f_gcol)
   );

   fnas_queue #(.DATA_W(Q_W)) u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready), .push_data({f_gcol, f_item}),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data({b_gcol, b_item})
   );

   fnas_back #(.MAX_GRID_COLS(MAX_GRID_COLS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .pop_valid(b_valid), .pop_ready(b_ready),
      .pop_item(b_item), .pop_gcol(b_gcol),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_center_row(rsp_center_row), .rsp_center_col(rsp_center_col),
      .rsp_similarity(rsp_similarity), .rsp_skipped(rsp_skipped),
      .rsp_last(rsp_last)
   );
endmodule

@@ design/fnas_checker.sv @@
// ----------------------------------------------------------------------------
// fnas_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "flow_neighbour_angle_similarity_assert.svh"

module fnas_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [18:0] rsp_similarity,
   input logic               rsp_skipped
);
   `FNAS_ASSERT_NOW(a_skip_zero, clock, reset, rsp_valid && rsp_skipped, rsp_similarity == 19'sd0, "skipped transaction with nonzero similarity")
   `FNAS_ASSERT_NOW(a_sim_range, clock, reset, rsp_valid, (rsp_similarity >= -19'sd163840) && (rsp_similarity <= 19'sd163835), "similarity out of range")
   `FNAS_ASSERT_NEXT(a_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `FNAS_ASSERT_NEXT(a_sim_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_similarity), "similarity changed while stalled")
endmodule

bind flow_neighbour_angle_similarity fnas_checker u_fnas_checker (.*);

@@ sim/tb_flow_neighbour_angle_similarity.sv @@
// ----------------------------------------------------------------------------
// tb_flow_neighbour_angle_similarity
// Self-checking testbench of the flow neighbour angle similarity block.
// Whole frames of flow vectors go in under several frame and grid settings.
// A CORDIC angle predictor with its own grid line store works out each
// neighbour similarity, and every result transaction is checked in order.
// ----------------------------------------------------------------------------
module tb_flow_neighbour_angle_similarity;
   import fnas_pkg::*;

   localparam int  MAX_COLS   = 1024;
   localparam int  CYCLE_CAP  = 3000000;
   localparam int  DRAIN_WAIT = 200;

   typedef struct {
      logic [9:0]         row;
      logic [9:0]         col;
      logic signed [18:0] sim;
      logic               skip;
      logic               last;
   } sim_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_flow_x = '0;
   logic signed [15:0] req_flow_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [9:0]         rsp_center_row;
   logic [9:0]         rsp_center_col;
   logic signed [18:0] rsp_similarity;
   logic               rsp_skipped;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [10:0]        csr_data = '0;

   flow_neighbour_angle_similarity DUT (.*);

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURNS [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

   logic [ANGLE_BITS-1:0] line_angle [3][MAX_COLS];
   logic                  line_skip  [3][MAX_COLS];
   int                    row_pos = 0;
   int                    col_pos = 0;
   logic [10:0]           width_reg = 11'd640;
   logic [10:0]           height_reg = 11'd480;
   logic [4:0]            step_reg = 5'd1;

   sim_result_type expected_results[$];
   bit             failed = 1'b0;
   bit             no_idle = 1'b0;
   int             cycle_count = 0;
   int             items_sent = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int clamp_int(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int eff_width();
      return clamp_int(int'(width_reg), 1, 1024);
   endfunction

   function automatic int eff_height();
      return clamp_int(int'(height_reg), 1, 1024);
   endfunction

   function automatic int eff_step();
      return clamp_int(int'(step_reg), 1, 16);
   endfunction

   function automatic logic [ANGLE_BITS-1:0] flow_angle(longint x, longint y);
      longint      vx, vy, sx, sy;
      logic [31:0] z;
      vx = x * 16384;
      vy = y * 16384;
      z = '0;
      if (x == 0 && y == 0) return '0;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         z = 32'h80000000;
      end
      for (int i = 0; i < 30; i++) begin
         sx = vy >>> i;
         sy = vx >>> i;
         if (vy > 0) begin
            vx += sx; vy -= sy; z += ATAN_TURNS[i];
         end else begin
            vx -= sx; vy += sy; z -= ATAN_TURNS[i];
         end
      end
      z += 32'(1) << (31 - ANGLE_BITS);
      return z[31 -: ANGLE_BITS];
   endfunction

   function automatic longint wrap_delta(logic [ANGLE_BITS-1:0] a,
                                         logic [ANGLE_BITS-1:0] b);
      logic signed [ANGLE_BITS-1:0] d;
      d = a - b;
      return longint'(d);
   endfunction

   function automatic sim_result_type neighbour_result(int pr, int pc);
      sim_result_type r;
      int s, w, h, slot, gc;
      longint sum, cnt, sim;
      logic [ANGLE_BITS-1:0] ca;
      s = eff_step(); w = eff_width(); h = eff_height();
      slot = (pr / s) % 3;
      gc = (pc / s) % MAX_COLS;
      ca = line_angle[slot][gc];
      sum = 0; cnt = 0; sim = 0;
      if (!line_skip[slot][gc]) begin
         if (pr != 0) begin
            sum += 5 * wrap_delta(ca, line_angle[((pr - s) / s) % 3][gc]); cnt++;
         end
         if (pc != 0) begin
            sum += 5 * wrap_delta(ca, line_angle[slot][((pc - s) / s) % MAX_COLS]); cnt++;
         end
         if (pr + s < h) begin
            sum += 5 * wrap_delta(ca, line_angle[((pr + s) / s) % 3][gc]); cnt++;
         end
         if (pc + s < w) begin
            sum += 5 * wrap_delta(ca, line_angle[slot][((pc + s) / s) % MAX_COLS]); cnt++;
         end
         if (cnt != 0) sim = sum / cnt;
      end
      if (sim > 262143) sim = 262143;
      if (sim < -262144) sim = -262144;
      r.row = pr[9:0];
      r.col = pc[9:0];
      r.sim = sim[18:0];
      r.skip = line_skip[slot][gc];
      r.last = 1'b0;
      return r;
   endfunction

   // advance the raster position and queue whatever this vector releases
   task automatic predict_flow(logic signed [15:0] fx, logic signed [15:0] fy);
      int s, w, h, slot, gc, n;
      longint ax, ay;
      sim_result_type res[3];
      s = eff_step(); w = eff_width(); h = eff_height();
      n = 0;
      if (row_pos % s == 0 && col_pos % s == 0) begin
         slot = (row_pos / s) % 3;
         gc = (col_pos / s) % MAX_COLS;
         ax = fx < 0 ? -longint'(fx) : longint'(fx);
         ay = fy < 0 ? -longint'(fy) : longint'(fy);
         line_angle[slot][gc] = flow_angle(fx, fy);
         line_skip[slot][gc] = (ax < 256 && ay < 256);
         if (row_pos >= s) begin
            res[n] = neighbour_result(row_pos - s, col_pos);
            n = n + 1;
         end
         if (row_pos + s >= h) begin
            if (col_pos >= s) begin
               res[n] = neighbour_result(row_pos, col_pos - s);
               n = n + 1;
            end
            if (col_pos + s >= w) begin
               res[n] = neighbour_result(row_pos, col_pos);
               n = n + 1;
            end
         end
         if (n > 0) res[n - 1].last = 1'b1;
         for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic send_flow(logic signed [15:0] fx, logic signed [15:0] fy);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_flow_x <= fx;
      req_flow_y <= fy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_flow(fx, fy);
      items_sent++;
   endtask

   function automatic logic signed [15:0] pick_flow();
      case ($urandom_range(0, 5))
         0: return 16'($signed($urandom_range(0, 510)) - 255);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
         2: return 16'($signed($urandom_range(0, 4096)) - 2048);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_frames(int frames);
      repeat (frames * eff_width() * eff_height()) send_flow(pick_flow(), pick_flow());
   endtask

   // settle the block before touching the registers
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  width_reg = value;
         CSR_FRAME_HEIGHT: height_reg = value;
         CSR_GRID_STEP:    step_reg = value[4:0];
         default: ;
      endcase
   endtask

   task automatic set_frame(int w, int h, int s);
      drain_results();
      write_reg(CSR_GRID_STEP, 11'(s));
      write_reg(CSR_FRAME_WIDTH, 11'(w));
      write_reg(CSR_FRAME_HEIGHT, 11'(h));
   endtask

   task automatic test_directed_vectors();
      set_frame(4, 3, 1);
      send_flow(16'sd0, 16'sd0);
      send_flow(16'sh7FFF, -16'sh8000);
      send_flow(-16'sh8000, 16'sh7FFF);
      send_flow(16'sd255, -16'sd255);
      send_flow(16'sd256, 16'sd0);
      send_flow(-16'sd256, 16'sd0);
      send_flow(16'sd0, -16'sh8000);
      send_flow(-16'sd1, -16'sd1);
      send_flow(16'sh7FFF, 16'sh7FFF);
      send_flow(-16'sh8000, -16'sh8000);
      send_flow(16'sd100, 16'sd300);
      send_flow(-16'sd300, 16'sd5);
   endtask

   task automatic test_no_neighbours();
      set_frame(1, 1, 1);
      send_flow(16'sd4000, -16'sd700);
      send_flow(16'sd10, 16'sd20);
   endtask

   task automatic test_grid_steps();
      set_frame(9, 7, 3);
      send_frames(1);
      set_frame(17, 2, 16);
      send_frames(1);
      set_frame(5, 5, 0);
      send_frames(1);
      set_frame(18, 2, 31);
      send_frames(1);
   endtask

   task automatic test_frame_extremes();
      set_frame(6, 0, 1);
      send_frames(1);
      set_frame(0, 3, 1);
      send_frames(1);
   endtask

   task automatic test_random_frames();
      int goal;
      goal = items_sent + 70;
      while (items_sent < goal) begin
         if (items_sent > goal - 35) no_idle = 1'b1;
         set_frame($urandom_range(1, 8), $urandom_range(1, 6),
                   $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4));
         send_frames(1);
      end
   endtask

   always @(posedge clock) begin : rsp_stall
      int left;
      bit stalling;
      if (no_idle) begin
         rsp_ready <= 1'b1;
      end else if (left > 0) begin
         left--;
      end else begin
         stalling = $urandom_range(0, 2) == 0;
         left = stalling ? $urandom_range(1, 15) : $urandom_range(1, 40);
         rsp_ready <= !stalling;
      end
   end

   task automatic compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
         failed = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      sim_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result transaction row %0d col %0d", $time,
                     rsp_center_row, rsp_center_col);
            failed = 1'b1;
         end else begin
            e = expected_results.pop_front();
            compare_field("center_row", e.row, rsp_center_row);
            compare_field("center_col", e.col, rsp_center_col);
            compare_field("similarity", e.sim, rsp_similarity);
            compare_field("skipped", e.skip, rsp_skipped);
            compare_field("last", e.last, rsp_last);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_vectors();
      test_no_neighbours();
      test_grid_steps();
      test_frame_extremes();
      test_random_frames();
      drain_results();
      if (failed || expected_results.size() != 0) begin
         $display("TB_ERROR");
      end else begin
         $display("TB_OK");
      end
      $finish;
   end

endmodule

@@ flow_neighbour_angle_similarity.f @@
+incdir+design
design/fnas_pkg.sv
design/fnas_queue.sv
design/fnas_front.sv
design/fnas_back.sv
design/flow_neighbour_angle_similarity.sv
design/fnas_checker.sv
sim/tb_flow_neighbour_angle_similarity.sv
